// ===== hw/rtl/edmd_pkg.sv =====
// shared types and constants for the echo distance median dimmer
// used by edmd_ctrl, edmd_datapath and echo_distance_median_dimmer_top
package edmd_pkg;

    localparam int PULSE_W  = 16;
    localparam int DIST_W   = 15;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int BRIGHT_W = 8;
    localparam int LEVEL_W  = 4;
    localparam int TDATA_W  = 24;
    localparam int TUSER_W  = 2;

    // q4 cm per microsecond, as multiply then shift
    localparam logic [9:0] SPEED_MUL   = 10'd557;
    localparam int         SPEED_SHIFT = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DISTANCE  = 2'd3;

    localparam logic [CFG_W-1:0] MIN_DISTANCE_RST  = 10'd10;
    localparam logic [CFG_W-1:0] MAX_DISTANCE_RST  = 10'd100;
    localparam logic [CFG_W-1:0] HOLD_DISTANCE_RST = 10'd150;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd8;
    localparam int                 DIV_STEPS = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RANK,
        ST_DRAIN,
        ST_MEDIAN,
        ST_MAP,
        ST_DIV,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;       // take input word, compute distance
        logic insert;     // write sample into window
        logic reject;     // sample refused
        logic rank_step;  // compare window against one candidate
        logic median;     // form median from middle values
        logic div_start;  // level needs a division
        logic map_fixed;  // level is zero or eight
        logic div_step;   // one quotient bit
        logic apply;      // update brightness
        logic emit;       // load output register
    } cmd_t;

    typedef struct packed {
        logic sample_ok;
        logic rank_last;
        logic below_hold;
        logic needs_div;
        logic div_last;
        logic out_free;
    } stat_t;

    // level*255/8
    function automatic logic [BRIGHT_W-1:0] bright_of(input logic [LEVEL_W-1:0] level);
        logic [BRIGHT_W-1:0] b;
        case (level)
            4'd0:    b = 8'd0;
            4'd1:    b = 8'd31;
            4'd2:    b = 8'd63;
            4'd3:    b = 8'd95;
            4'd4:    b = 8'd127;
            4'd5:    b = 8'd159;
            4'd6:    b = 8'd191;
            4'd7:    b = 8'd223;
            4'd8:    b = 8'd255;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/edmd_ctrl.sv =====
// sequencing state machine for the echo distance median dimmer
// depends on edmd_pkg; drives edmd_datapath through cmd_t / stat_t
module edmd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  edmd_pkg::stat_t stat,
    input  logic           valid,
    output edmd_pkg::cmd_t  cmd
);
    import edmd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = 1'b1;
                if (valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.sample_ok)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_RANK;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.rank_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last candidate is counted in this cycle
                state_next = ST_MEDIAN;
            end
            ST_MEDIAN:
            begin
                cmd.median = 1'b1;
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (!stat.below_hold)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.map_fixed = 1'b1;
                    state_next    = ST_APPLY;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/edmd_datapath.sv =====
// datapath: config registers, sample window, rank counter, level divider, output register
// depends on edmd_pkg; commanded by edmd_ctrl
module edmd_datapath #(
    parameter int WINDOW = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  edmd_pkg::cmd_t                     cmd,
    output edmd_pkg::stat_t                    stat,
    input  logic [edmd_pkg::PULSE_W-1:0]       pulse,
    input  logic                               cfg_we,
    input  logic [edmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edmd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [edmd_pkg::TDATA_W-1:0]       out_data,
    output logic [edmd_pkg::TUSER_W-1:0]       out_user
);
    import edmd_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PROD_W = PULSE_W + 10;

    // configuration
    logic             enabled_reg;
    logic [CFG_W-1:0] min_reg;
    logic [CFG_W-1:0] max_reg;
    logic [CFG_W-1:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            min_reg     <= MIN_DISTANCE_RST;
            max_reg     <= MAX_DISTANCE_RST;
            hold_reg    <= HOLD_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SENSOR_ENABLED: enabled_reg <= cfg_data[0];
                REG_MIN_DISTANCE:   min_reg     <= cfg_data;
                REG_MAX_DISTANCE:   max_reg     <= cfg_data;
                REG_HOLD_DISTANCE:  hold_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // distance conversion
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] dist_reg;

    assign prod = PROD_W'(pulse) * PROD_W'(SPEED_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dist_reg <= prod[SPEED_SHIFT +: DIST_W];
        end
    end

    // window; slots 0..fill-1 always hold the samples
    logic [DIST_W-1:0] win_reg [WINDOW];
    logic [CNT_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  oldest_reg;
    logic              full;
    logic [IDX_W-1:0]  slot;

    assign full = (fill_reg == CNT_W'(WINDOW));
    assign slot = full ? oldest_reg : fill_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            win_reg[slot] <= dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.insert)
        begin
            if (!full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (oldest_reg == IDX_W'(WINDOW - 1))
            begin
                oldest_reg <= '0;
            end
            else
            begin
                oldest_reg <= oldest_reg + 1'b1;
            end
        end
    end

    // rank pass: compare stage then count stage
    logic [IDX_W-1:0]  rank_idx_reg;
    logic [DIST_W-1:0] cand;
    logic [WINDOW-1:0] lt_mask;
    logic [WINDOW-1:0] le_mask;
    logic [WINDOW-1:0] lt_mask_reg;
    logic [WINDOW-1:0] le_mask_reg;
    logic [DIST_W-1:0] cand_reg;
    logic              cnt_pending_reg;
    logic [CNT_W-1:0]  lt_cnt;
    logic [CNT_W-1:0]  le_cnt;
    logic [CNT_W-1:0]  k_hi;
    logic [CNT_W-1:0]  k_lo;
    logic [DIST_W-1:0] mid_lo_reg;
    logic [DIST_W-1:0] mid_hi_reg;

    assign cand = win_reg[rank_idx_reg];

    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            lt_mask[j] = (CNT_W'(j) < fill_reg) && (win_reg[j] < cand);
            le_mask[j] = (CNT_W'(j) < fill_reg) && (win_reg[j] <= cand);
        end
    end

    always_comb
    begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            lt_cnt = lt_cnt + CNT_W'(lt_mask_reg[j]);
            le_cnt = le_cnt + CNT_W'(le_mask_reg[j]);
        end
    end

    // middle positions of the sorted window
    assign k_hi = fill_reg >> 1;
    assign k_lo = fill_reg[0] ? k_hi : k_hi - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_idx_reg    <= '0;
            cnt_pending_reg <= 1'b0;
        end
        else
        begin
            cnt_pending_reg <= cmd.rank_step;
            if (cmd.insert)
            begin
                rank_idx_reg <= '0;
            end
            else if (cmd.rank_step)
            begin
                rank_idx_reg <= rank_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_step)
        begin
            lt_mask_reg <= lt_mask;
            le_mask_reg <= le_mask;
            cand_reg    <= cand;
        end
        if (cnt_pending_reg)
        begin
            // candidate covers sorted positions lt_cnt .. le_cnt-1
            if ((lt_cnt <= k_lo) && (k_lo < le_cnt))
            begin
                mid_lo_reg <= cand_reg;
            end
            if ((lt_cnt <= k_hi) && (k_hi < le_cnt))
            begin
                mid_hi_reg <= cand_reg;
            end
        end
    end

    // median, level mapping and brightness
    logic [DIST_W:0]     mid_sum;
    logic [DIST_W-1:0]   median_reg;
    logic [DIST_W-1:0]   lo_q4;
    logic [DIST_W-1:0]   hi_q4;
    logic [DIST_W-1:0]   hold_q4;
    logic [DIST_W-1:0]   span;
    logic [DIST_W-1:0]   rem_reg;
    logic [DIST_W:0]     rem_shift;
    logic                q_bit;
    logic [1:0]          div_cnt_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [BRIGHT_W-1:0] bright_new;
    logic                valid_flag_reg;
    logic                changed_flag_reg;

    assign mid_sum   = {1'b0, mid_lo_reg} + {1'b0, mid_hi_reg};
    assign lo_q4     = {1'b0, min_reg, 4'b0000};
    assign hi_q4     = {1'b0, max_reg, 4'b0000};
    assign hold_q4   = {1'b0, hold_reg, 4'b0000};
    assign span      = hi_q4 - lo_q4;
    assign rem_shift = {rem_reg, 1'b0};
    assign q_bit     = (rem_shift >= {1'b0, span});
    assign bright_new = bright_of(level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg       <= '0;
            bright_reg       <= '0;
            div_cnt_reg      <= '0;
            valid_flag_reg   <= 1'b0;
            changed_flag_reg <= 1'b0;
        end
        else
        begin
            if (cmd.reject)
            begin
                valid_flag_reg   <= 1'b0;
                changed_flag_reg <= 1'b0;
            end
            if (cmd.insert)
            begin
                valid_flag_reg   <= 1'b1;
                changed_flag_reg <= 1'b0;
            end
            if (cmd.median)
            begin
                median_reg <= mid_sum[DIST_W:1];
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.apply && (bright_new != bright_reg))
            begin
                bright_reg       <= bright_new;
                changed_flag_reg <= 1'b1;
            end
        end
    end

    // restoring division: remainder stays below span, quotient below eight
    always_ff @(posedge clk)
    begin
        if (cmd.map_fixed)
        begin
            level_reg <= (median_reg <= lo_q4) ? '0 : LEVEL_MAX;
        end
        else if (cmd.div_start)
        begin
            rem_reg   <= median_reg - lo_q4;
            level_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= q_bit ? DIST_W'(rem_shift - {1'b0, span}) : rem_shift[DIST_W-1:0];
            level_reg <= {level_reg[LEVEL_W-2:0], q_bit};
        end
    end

    // output register
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg;
    logic [TUSER_W-1:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {1'b0, bright_reg, median_reg};
            out_user_reg <= {changed_flag_reg, valid_flag_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // status
    assign stat.sample_ok  = enabled_reg && (dist_reg != '0);
    assign stat.rank_last  = (CNT_W'(rank_idx_reg) == fill_reg - 1'b1);
    assign stat.below_hold = (median_reg < hold_q4);
    assign stat.needs_div  = (median_reg > lo_q4) && (median_reg < hi_q4);
    assign stat.div_last   = (div_cnt_reg == 2'(DIV_STEPS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== hw/rtl/echo_distance_median_dimmer_top.sv =====
// channel    dir  signals                               word
// s_axis     in   s_axis_tvalid/tready/tdata            echo pulse width, us
// m_axis     out  m_axis_tvalid/tready/tdata/tuser      median, brightness, flags
// cfg        in   cfg_valid/cfg_ready/cfg_index/data    register write
//
// per word, n = fill count after the insert: a rejected word goes from check to emit;
// an accepted word runs the rank pass over n candidates and forms the median, then emits at
// or above hold, or maps the level (fixed for zero or eight, else the divider) and applies it.
// the rank pass compares one candidate per cycle; emit waits while the output word is held.
// rst_n clears the window fill count, median and brightness; cfg is always ready.
// the next word is taken while the previous result waits in the output register.
//
// top level: echo distance median dimmer; depends on edmd_pkg, edmd_ctrl, edmd_datapath
module echo_distance_median_dimmer_top #(
    parameter int WINDOW = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [edmd_pkg::PULSE_W-1:0]       s_axis_tdata,   // [15:0] pulse_width_us
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [edmd_pkg::TDATA_W-1:0]       m_axis_tdata,   // [14:0] median_distance,
                                                               // [22:15] brightness_out, [23] zero
    output logic [edmd_pkg::TUSER_W-1:0]       m_axis_tuser,   // [0] sample_valid,
                                                               // [1] brightness_changed
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [edmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edmd_pkg::CFG_W-1:0]         cfg_data
);
    import edmd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_take;

    assign s_axis_tready = cmd.load;
    assign cfg_ready     = 1'b1;

    // the controller waits in idle until a word arrives
    cmd_t cmd_gated;
    always_comb
    begin
        cmd_gated      = cmd;
        cmd_gated.load = in_take;
    end
    assign in_take = cmd.load && s_axis_tvalid;

    edmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .valid (s_axis_tvalid),
        .cmd   (cmd)
    );

    edmd_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_gated),
        .stat      (stat),
        .pulse     (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
